// ===== design/bfq_pkg.sv =====
// shared types and constants for the bounded fifo queue core
package bfq_pkg;

    // fixed field widths
    localparam int COUNT_W = 5;
    localparam int FIELD_W = 32;
    localparam int STAT_W  = 2;
    localparam int MODE_W  = 2;

    // capacity after reset
    localparam logic [COUNT_W-1:0] CAP_RESET = 5'd16;

    // largest count the occupancy field can carry
    localparam int COUNT_MAX = 31;

    // operation codes
    typedef enum logic [MODE_W-1:0] {
        MODE_PUSH  = 2'd0,
        MODE_POP   = 2'd1,
        MODE_CLEAR = 2'd2,
        MODE_QUERY = 2'd3
    } mode_t;

    // result status codes
    typedef enum logic [STAT_W-1:0] {
        STAT_DONE  = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } status_t;

    // controller commands to the datapath
    typedef struct packed {
        logic latch_in;   // capture the input beat
        logic exec;       // apply the operation to pointers, count and store
        logic load_out;   // copy the result into the output register
    } bfq_cmd_t;

endpackage

// ===== design/bfq_ctrl.sv =====
// controller state machine for the bounded fifo queue core
module bfq_ctrl
    import bfq_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    output logic     m_valid,
    input  logic     m_ready,
    output bfq_cmd_t cmd
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_EXEC = 4'b0010,
        ST_READ = 4'b0100,
        ST_RESP = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;

    // output register can take a new result
    assign out_free = !m_valid_reg || m_ready;

    // next state and commands
    always_comb begin
        state_next   = state_reg;
        cmd.latch_in = 1'b0;
        cmd.exec     = 1'b0;
        cmd.load_out = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.latch_in = 1'b1;
                    state_next   = ST_EXEC;
                end
            end
            ST_EXEC: begin
                cmd.exec   = 1'b1;
                state_next = ST_READ;
            end
            ST_READ: begin
                state_next = ST_RESP;
            end
            ST_RESP: begin
                if (out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output valid flag
    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

endmodule

// ===== design/bfq_datapath.sv =====
// ring storage, pointers, count and result register of the fifo queue
module bfq_datapath
    import bfq_pkg::*;
#(
    parameter int DEPTH      = 16,
    parameter int ELEM_BYTES = 4
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  bfq_cmd_t           cmd,
    input  logic               cfg_wr_en,
    input  logic [COUNT_W-1:0] cfg_wr_data,
    input  logic [MODE_W-1:0]  s_mode,
    input  logic [FIELD_W-1:0] s_push_data,
    output logic [STAT_W-1:0]  m_status,
    output logic [COUNT_W-1:0] m_occupancy,
    output logic               m_holds_any,
    output logic [FIELD_W-1:0] m_front_value,
    output logic [FIELD_W-1:0] m_rear_value
);

    localparam int PTR_W     = $clog2(DEPTH);
    localparam int ELEM_W    = (ELEM_BYTES * 8 > FIELD_W) ? FIELD_W : ELEM_BYTES * 8;
    localparam int DEPTH_LIM = (DEPTH > COUNT_MAX) ? COUNT_MAX : DEPTH;

    localparam logic [PTR_W-1:0]   LAST_SLOT = PTR_W'(DEPTH - 1);
    localparam logic [COUNT_W-1:0] DEPTH_CNT = COUNT_W'(DEPTH_LIM);

    // element store
    logic [ELEM_W-1:0] mem [DEPTH];

    logic [COUNT_W-1:0] cap_reg;
    mode_t              mode_reg;
    logic [ELEM_W-1:0]  data_reg;

    logic [PTR_W-1:0]   head_reg, head_next;
    logic [PTR_W-1:0]   tail_reg, tail_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    status_t            stat_reg, stat_next;
    logic               wr_en;
    logic [COUNT_W-1:0] limit;
    logic [PTR_W-1:0]   rear_addr;

    logic [ELEM_W-1:0]  rd_front_reg;
    logic [ELEM_W-1:0]  rd_rear_reg;

    status_t            out_stat_reg;
    logic [COUNT_W-1:0] out_count_reg;
    logic               out_any_reg;
    logic [FIELD_W-1:0] out_front_reg;
    logic [FIELD_W-1:0] out_rear_reg;

    // effective capacity never above the ring size
    assign limit = (cap_reg > DEPTH_CNT) ? DEPTH_CNT : cap_reg;

    // slot holding the newest element
    assign rear_addr = (tail_reg == '0) ? LAST_SLOT : tail_reg - PTR_W'(1);

    // operation on pointers and count
    always_comb begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        stat_next  = stat_reg;
        wr_en      = 1'b0;
        if (cmd.exec) begin
            stat_next = STAT_DONE;
            case (mode_reg)
                MODE_PUSH: begin
                    if (count_reg >= limit) begin
                        stat_next = STAT_FULL;
                    end else begin
                        wr_en      = 1'b1;
                        tail_next  = (tail_reg == LAST_SLOT) ? '0 : tail_reg + PTR_W'(1);
                        count_next = count_reg + COUNT_W'(1);
                    end
                end
                MODE_POP: begin
                    if (count_reg == '0) begin
                        stat_next = STAT_EMPTY;
                    end else begin
                        head_next  = (head_reg == LAST_SLOT) ? '0 : head_reg + PTR_W'(1);
                        count_next = count_reg - COUNT_W'(1);
                    end
                end
                MODE_CLEAR: begin
                    head_next  = '0;
                    tail_next  = '0;
                    count_next = '0;
                end
                MODE_QUERY: begin
                end
                default: begin
                end
            endcase
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg   <= CAP_RESET;
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end else begin
            if (cfg_wr_en) begin
                cap_reg <= cfg_wr_data;
            end
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    // input beat capture and status
    always_ff @(posedge aclk) begin
        if (cmd.latch_in) begin
            mode_reg <= mode_t'(s_mode);
            data_reg <= s_push_data[ELEM_W-1:0];
        end
        stat_reg <= stat_next;
    end

    // store write and registered reads at front and rear
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[tail_reg] <= data_reg;
        end
        rd_front_reg <= mem[head_reg];
        rd_rear_reg  <= mem[rear_addr];
    end

    // result register
    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_stat_reg  <= stat_reg;
            out_count_reg <= count_reg;
            out_any_reg   <= (count_reg != '0);
            out_front_reg <= (count_reg != '0) ? FIELD_W'(rd_front_reg) : '0;
            out_rear_reg  <= (count_reg != '0) ? FIELD_W'(rd_rear_reg) : '0;
        end
    end

    assign m_status      = out_stat_reg;
    assign m_occupancy   = out_count_reg;
    assign m_holds_any   = out_any_reg;
    assign m_front_value = out_front_reg;
    assign m_rear_value  = out_rear_reg;

endmodule

// ===== design/bounded_fifo_queue_core.sv =====
// top level of the bounded fifo queue core
//
// Bounded first-in first-out queue of ELEM_BYTES-wide elements held in a
// ring of DEPTH slots. Each input beat on the s_ channel carries an
// operation (push, pop, clear, query) and push data; each one returns
// exactly one result beat on the m_ channel with status, occupancy, and
// the front and rear elements after the operation (zero when empty).
// The capacity register is written through cfg_wr_en / cfg_wr_data; the
// user must write it only while no operation is in flight (the block
// itself does not enforce this). It resets to 16, and its effective value
// is clamped to DEPTH and to 31. Each operation walks the controller
// through capture, update, memory read and result load; the store read is
// registered, so front and rear are read in the cycle after the pointer
// update. s_ready is high only in the capture state; a result waiting in
// the output register does not block the next beat, but a later result
// waits there until m_ready takes the earlier one.
// Reset (synchronous, active low) empties the queue, sets capacity to 16
// and drops m_valid; the element store itself is not cleared.
module bounded_fifo_queue_core
    import bfq_pkg::*;
#(
    parameter int DEPTH      = 16,
    parameter int ELEM_BYTES = 4
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [COUNT_W-1:0] cfg_wr_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [MODE_W-1:0]  s_mode,
    input  logic [FIELD_W-1:0] s_push_data,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [STAT_W-1:0]  m_status,
    output logic [COUNT_W-1:0] m_occupancy,
    output logic               m_holds_any,
    output logic [FIELD_W-1:0] m_front_value,
    output logic [FIELD_W-1:0] m_rear_value
);

    bfq_cmd_t cmd;

    // sequencing
    bfq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    // storage and result
    bfq_datapath #(
        .DEPTH      (DEPTH),
        .ELEM_BYTES (ELEM_BYTES)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_mode        (s_mode),
        .s_push_data   (s_push_data),
        .m_status      (m_status),
        .m_occupancy   (m_occupancy),
        .m_holds_any   (m_holds_any),
        .m_front_value (m_front_value),
        .m_rear_value  (m_rear_value)
    );

    // one operation in flight: ready drops after an accepted beat
    a_single_op: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted while an operation is in flight");

    // occupancy never exceeds the ring size
    a_occ_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_occupancy <= DEPTH))
        else $error("occupancy beyond ring size");

    // holds_any follows the occupancy
    a_any_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_holds_any == (m_occupancy != '0)))
        else $error("holds_any disagrees with occupancy");

    // empty queue reports zero front and rear
    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_holds_any) |-> (m_front_value == '0 && m_rear_value == '0))
        else $error("nonzero element reported on empty queue");

endmodule
